// ----- rtl/ldld_pkg.sv -----
`timescale 1ns / 1ps
package ldld_pkg;

  localparam int LAG_W      = 4;
  localparam int LINE_NUM_W = 32;
  localparam int LINE_LEN_W = 10;
  localparam int DATA_W     = 32;
  localparam int CFG_ADDR_W = 3;

  localparam logic [7:0]       NEWLINE_CODE = 8'd10;
  localparam logic [7:0]       ZERO_BYTE    = 8'd0;
  localparam logic [LAG_W-1:0] LAG_RESET    = 4'd1;

  // Register index, taken from the word-address bit of paddr.
  localparam logic REG_IDX_LAG = 1'b0;

  typedef struct packed {
    logic [LINE_NUM_W-1:0] line_number;
    logic [LINE_LEN_W-1:0] line_length;
  } result_t;

endpackage

// ----- rtl/ldld_line_mem.sv -----
`timescale 1ns / 1ps
module ldld_line_mem #(
  parameter int SLOTS = 16,
  parameter int DEPTH = 1024
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [$clog2(SLOTS)-1:0]   wr_slot,
  input  logic [$clog2(DEPTH)-1:0]   wr_pos,
  input  logic [7:0]                 wr_data,
  input  logic [$clog2(SLOTS)-1:0]   rd_slot,
  input  logic [$clog2(DEPTH)-1:0]   rd_pos,
  output logic [7:0]                 rd_data,
  input  logic [$clog2(SLOTS)-1:0]   rd2_slot,
  input  logic [$clog2(DEPTH)-1:0]   rd2_pos,
  output logic [7:0]                 rd2_data
);

  logic [7:0] mem [0:SLOTS-1][0:DEPTH-1];
  logic [7:0] rd_data_r;
  logic [7:0] rd2_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_slot][wr_pos] <= wr_data;
    end
    rd_data_r  <= mem[rd_slot][rd_pos];
    rd2_data_r <= mem[rd2_slot][rd2_pos];
  end

  assign rd_data  = rd_data_r;
  assign rd2_data = rd2_data_r;

endmodule

// ----- rtl/ldld_len_mem.sv -----
`timescale 1ns / 1ps
module ldld_len_mem #(
  parameter int SLOTS = 16,
  parameter int LEN_W = 10
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(SLOTS)-1:0] wr_slot,
  input  logic [LEN_W-1:0]         wr_data,
  input  logic [$clog2(SLOTS)-1:0] rd_slot,
  output logic [LEN_W-1:0]         rd_data
);

  logic [LEN_W-1:0] mem [0:SLOTS-1];
  logic [LEN_W-1:0] rd_data_r;

  // Write-first: a read of the slot being written returns the new length.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_slot] <= wr_data;
    end
    if (wr_en && (wr_slot == rd_slot)) begin
      rd_data_r <= wr_data;
    end else begin
      rd_data_r <= mem[rd_slot];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/ldld_out_queue.sv -----
`timescale 1ns / 1ps
module ldld_out_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  ldld_pkg::result_t push_data,
  output logic              full,
  output logic              out_valid,
  input  logic              out_stall,
  output ldld_pkg::result_t out_data
);
  import ldld_pkg::*;

  logic [1:0] count_r, count_nxt;
  result_t    q0_r, q0_nxt;
  result_t    q1_r, q1_nxt;
  logic       pop;

  assign out_valid = (count_r != 2'd0);
  assign full      = (count_r == 2'd2);
  assign pop       = out_valid && !out_stall;
  assign out_data  = q0_r;

  always_comb begin
    count_nxt = count_r;
    q0_nxt    = q0_r;
    q1_nxt    = q1_r;
    case (count_r)
      2'd0: begin
        if (push) begin
          q0_nxt    = push_data;
          count_nxt = 2'd1;
        end
      end
      2'd1: begin
        if (pop && push) begin
          q0_nxt = push_data;
        end else if (push) begin
          q1_nxt    = push_data;
          count_nxt = 2'd2;
        end else if (pop) begin
          count_nxt = 2'd0;
        end
      end
      2'd2: begin
        if (pop) begin
          q0_nxt    = q1_r;
          count_nxt = 2'd1;
        end
      end
      default: begin
        count_nxt = 2'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 2'd0;
    end else begin
      count_r <= count_nxt;
    end
    q0_r <= q0_nxt;
    q1_r <= q1_nxt;
  end

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("result pushed into a full output queue");

  a_pop_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (count_r == 2'd1 || count_r == 2'd2))
    else $error("output queue popped while empty");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop && count_r == 2'd1) |=> (count_r == 2'd2))
    else $error("output queue lost a pushed result");

endmodule

// ----- rtl/lagged_duplicate_line_detector_core.sv -----
`timescale 1ns / 1ps
// A matching line's result is pushed into the output queue in the cycle of its newline transaction.
// Throughput: one byte per cycle while the input is not stalled; the line store takes one write and one read per byte.
// The input stalls while two results wait in the output queue, in the cycle of a lag write,
// and then while the effective bytes of the partial line are walked again against the new earlier line.
// Reset (rst_n, synchronous, active low) clears the control state and sets the lag to one;
// the line store and length memories are not cleared and need no clearing pass.
module lagged_duplicate_line_detector_core #(
  parameter int MAX_SLOTS  = 16,
  parameter int LINE_BYTES = 1024
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [7:0]                          in_byte,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [ldld_pkg::LINE_NUM_W-1:0]     out_line_number,
  output logic [ldld_pkg::LINE_LEN_W-1:0]     out_line_length,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [ldld_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [ldld_pkg::DATA_W-1:0]         pwdata,
  output logic [ldld_pkg::DATA_W-1:0]         prdata,
  output logic                                pready
);
  import ldld_pkg::*;

  localparam int SLOT_W = $clog2(MAX_SLOTS);
  localparam int POS_W  = $clog2(LINE_BYTES);

  function automatic logic [SLOT_W-1:0] sat_lag(input logic [LAG_W-1:0] lag);
    if (32'(lag) > MAX_SLOTS - 1) begin
      return SLOT_W'(MAX_SLOTS - 1);
    end
    return SLOT_W'(lag);
  endfunction

  function automatic logic [SLOT_W-1:0] back_slot(input logic [SLOT_W-1:0] slot,
                                                  input logic [SLOT_W-1:0] lag);
    logic [SLOT_W:0] wrapped;
    wrapped = {1'b0, slot} + (SLOT_W+1)'(MAX_SLOTS) - {1'b0, lag};
    if (slot >= lag) begin
      return slot - lag;
    end
    return wrapped[SLOT_W-1:0];
  endfunction

  logic [LAG_W-1:0]      lag_r, lag_nxt;
  logic [SLOT_W-1:0]     cur_slot_r, cur_slot_nxt;
  logic [POS_W-1:0]      pos_r, pos_nxt;
  logic [POS_W-1:0]      eff_len_r, eff_len_nxt;
  logic                  zero_seen_r, zero_seen_nxt;
  logic                  mismatch_r, mismatch_nxt;
  logic [LINE_NUM_W-1:0] lines_r, lines_nxt;
  logic                  s1_cmp_r;
  logic [7:0]            s1_byte_r;
  logic                  scan_busy_r, scan_busy_nxt;
  logic [POS_W-1:0]      scan_pos_r, scan_pos_nxt;
  logic                  scan_cmp_r;

  logic                  cfg_wr, lag_wr;
  logic                  in_acc, is_nl, nl_acc, store_ok, byte_wr, cmp_en;
  logic                  scan_issue;
  logic [POS_W-1:0]      line_rd_pos;
  logic [SLOT_W-1:0]     lag_sat, other_slot, len_rd_slot;
  logic [7:0]            other_byte, cur_byte;
  logic [POS_W-1:0]      other_len;
  logic                  mismatch_eff, match, push;
  logic [LINE_NUM_W-1:0] lines_inc;
  logic                  q_full;
  result_t               push_data, out_data;

  // Configuration port.
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign lag_wr  = cfg_wr && (paddr[2] == REG_IDX_LAG);
  assign lag_nxt = lag_wr ? pwdata[LAG_W-1:0] : lag_r;
  assign prdata  = (paddr[2] == REG_IDX_LAG) ? DATA_W'(lag_r) : '0;

  // A new lag makes the running compare of a partial line stale, so the line
  // is walked again against the new earlier line before more input is taken.
  assign in_stall   = q_full || scan_busy_r || lag_wr;
  assign in_acc     = in_valid && !in_stall;
  assign is_nl      = (in_byte == NEWLINE_CODE);
  assign nl_acc     = in_acc && is_nl;
  assign store_ok   = (pos_r != POS_W'(LINE_BYTES - 1));
  assign byte_wr    = in_acc && !is_nl && store_ok;
  assign cmp_en     = byte_wr && !zero_seen_r && (in_byte != ZERO_BYTE);
  assign scan_issue = scan_busy_r && (scan_pos_r != eff_len_r);

  assign lag_sat     = sat_lag(lag_r);
  assign other_slot  = back_slot(cur_slot_r, lag_sat);
  assign line_rd_pos = scan_busy_r ? scan_pos_r : pos_r;

  // Each stored byte before the first zero byte is checked against the same position of the
  // earlier line; the check lands in the following cycle, when the read data is back.
  ldld_line_mem #(
    .SLOTS (MAX_SLOTS),
    .DEPTH (LINE_BYTES)
  ) u_line_mem (
    .clk      (clk),
    .wr_en    (byte_wr),
    .wr_slot  (cur_slot_r),
    .wr_pos   (pos_r),
    .wr_data  (in_byte),
    .rd_slot  (other_slot),
    .rd_pos   (line_rd_pos),
    .rd_data  (other_byte),
    .rd2_slot (cur_slot_r),
    .rd2_pos  (scan_pos_r),
    .rd2_data (cur_byte)
  );

  // The earlier line's length is fetched ahead, for the slot and lag of the next cycle.
  assign len_rd_slot = back_slot(cur_slot_nxt, sat_lag(lag_nxt));

  ldld_len_mem #(
    .SLOTS (MAX_SLOTS),
    .LEN_W (POS_W)
  ) u_len_mem (
    .clk     (clk),
    .wr_en   (nl_acc),
    .wr_slot (cur_slot_r),
    .wr_data (eff_len_r),
    .rd_slot (len_rd_slot),
    .rd_data (other_len)
  );

  assign mismatch_eff = mismatch_r || (s1_cmp_r && (other_byte != s1_byte_r)) ||
                        (scan_cmp_r && (other_byte != cur_byte));
  assign lines_inc    = (lines_r == '1) ? lines_r : lines_r + LINE_NUM_W'(1);
  assign match        = (lag_sat == '0) || (!mismatch_eff && (eff_len_r == other_len));
  assign push         = nl_acc && (lines_inc > LINE_NUM_W'(lag_sat)) && match;

  assign push_data.line_number = lines_inc;
  assign push_data.line_length = LINE_LEN_W'(eff_len_r);

  always_comb begin
    cur_slot_nxt  = cur_slot_r;
    pos_nxt       = pos_r;
    eff_len_nxt   = eff_len_r;
    zero_seen_nxt = zero_seen_r;
    mismatch_nxt  = mismatch_eff;
    lines_nxt     = lines_r;
    scan_busy_nxt = scan_busy_r;
    scan_pos_nxt  = scan_pos_r;
    if (nl_acc) begin
      cur_slot_nxt  = (cur_slot_r == SLOT_W'(MAX_SLOTS - 1)) ? '0
                                                              : cur_slot_r + SLOT_W'(1);
      pos_nxt       = '0;
      eff_len_nxt   = '0;
      zero_seen_nxt = 1'b0;
      mismatch_nxt  = 1'b0;
      lines_nxt     = lines_inc;
    end else if (byte_wr) begin
      pos_nxt = pos_r + POS_W'(1);
      if (cmp_en) begin
        eff_len_nxt = eff_len_r + POS_W'(1);
      end
      if (!zero_seen_r && in_byte == ZERO_BYTE) begin
        zero_seen_nxt = 1'b1;
      end
    end
    if (lag_wr) begin
      scan_busy_nxt = 1'b1;
      scan_pos_nxt  = '0;
      mismatch_nxt  = 1'b0;
    end else if (scan_busy_r) begin
      if (scan_issue) begin
        scan_pos_nxt = scan_pos_r + POS_W'(1);
      end else begin
        scan_busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lag_r       <= LAG_RESET;
      cur_slot_r  <= '0;
      pos_r       <= '0;
      eff_len_r   <= '0;
      zero_seen_r <= 1'b0;
      mismatch_r  <= 1'b0;
      lines_r     <= '0;
      s1_cmp_r    <= 1'b0;
      scan_busy_r <= 1'b0;
      scan_pos_r  <= '0;
      scan_cmp_r  <= 1'b0;
    end else begin
      lag_r       <= lag_nxt;
      cur_slot_r  <= cur_slot_nxt;
      pos_r       <= pos_nxt;
      eff_len_r   <= eff_len_nxt;
      zero_seen_r <= zero_seen_nxt;
      mismatch_r  <= mismatch_nxt;
      lines_r     <= lines_nxt;
      s1_cmp_r    <= cmp_en;
      scan_busy_r <= scan_busy_nxt;
      scan_pos_r  <= scan_pos_nxt;
      scan_cmp_r  <= scan_issue && !lag_wr;
    end
    s1_byte_r <= in_byte;
  end

  ldld_out_queue u_out_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign out_line_number = out_data.line_number;
  assign out_line_length = out_data.line_length;

  a_newline_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    nl_acc |=> (pos_r == '0 && eff_len_r == '0 && !zero_seen_r && !mismatch_r))
    else $error("line state not restarted after a newline");

  a_cmp_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
    s1_cmp_r |-> $past(in_valid && !in_stall))
    else $error("byte compare pending without an accepted transaction");

  a_stall_means_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid || scan_busy_r || lag_wr))
    else $error("input stalled while no result is waiting");

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
  import ldld_pkg::*;

  localparam int MAX_SLOTS  = 16;
  localparam int LINE_BYTES = 1024;
  localparam logic [CFG_ADDR_W-1:0] LAG_ADDR   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] UNUSED_ADDR = 3'd4;
  localparam int MAX_REPORTS = 100;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] in_byte = 8'd0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [LINE_NUM_W-1:0] out_line_number;
  logic [LINE_LEN_W-1:0] out_line_length;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;

  lagged_duplicate_line_detector_core #(
    .MAX_SLOTS (MAX_SLOTS),
    .LINE_BYTES(LINE_BYTES)
  ) DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_byte        (in_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_line_number(out_line_number),
    .out_line_length(out_line_length),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  // Mirror of the detector state.
  bit [7:0] line_mem [MAX_SLOTS][LINE_BYTES];
  int unsigned slot_len [MAX_SLOTS];
  int unsigned wr_slot = 0;
  int unsigned wr_pos = 0;
  logic [LINE_LEN_W-1:0] eff_len = '0;
  bit zero_seen = 1'b0;
  logic [LINE_NUM_W-1:0] lines_done = '0;
  logic [LAG_W-1:0] lag_cfg = LAG_RESET;

  result_t pending_matches[$];
  int error_count = 0;
  int items_sent = 0;
  int in_gap_max = 0;
  int out_gap_max = 0;
  int sink_wait = 0;
  int hold_request = 0;
  logic sink_hold = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("testbench: errors");
    $finish;
  end

  function automatic void note_error();
    error_count++;
  endfunction

  // Advances the mirror by one accepted byte and queues the match it causes.
  function automatic void track_byte(input logic [7:0] b);
    int unsigned lag;
    int unsigned other;
    bit same;
    if (b != NEWLINE_CODE) begin
      if (wr_pos < LINE_BYTES - 1) begin
        line_mem[wr_slot][wr_pos] = b;
        wr_pos++;
        if (!zero_seen) begin
          if (b == ZERO_BYTE) zero_seen = 1'b1;
          else eff_len++;
        end
      end
      return;
    end
    slot_len[wr_slot] = eff_len;
    if (lines_done != '1) lines_done++;
    lag = (lag_cfg > MAX_SLOTS - 1) ? MAX_SLOTS - 1 : lag_cfg;
    if (lines_done > lag) begin
      other = (wr_slot + MAX_SLOTS - lag) % MAX_SLOTS;
      same = (slot_len[wr_slot] == slot_len[other]);
      for (int k = 0; same && k < slot_len[wr_slot]; k++) begin
        if (line_mem[wr_slot][k] != line_mem[other][k]) same = 1'b0;
      end
      if (same) pending_matches.push_back('{line_number: lines_done, line_length: eff_len});
    end
    wr_slot = (wr_slot + 1) % MAX_SLOTS;
    wr_pos = 0;
    eff_len = '0;
    zero_seen = 1'b0;
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_matches.size() == 0) begin
        if (error_count < MAX_REPORTS)
          $display("%0t: unexpected result, expected none, actual line %0d length %0d",
                   $time, out_line_number, out_line_length);
        note_error();
      end else begin
        want = pending_matches.pop_front();
        if (out_line_number !== want.line_number || out_line_length !== want.line_length) begin
          if (error_count < MAX_REPORTS)
            $display("%0t: mismatch, expected line %0d length %0d, actual line %0d length %0d",
                     $time, want.line_number, want.line_length, out_line_number,
                     out_line_length);
          note_error();
        end
      end
      sink_wait = $urandom_range(0, out_gap_max);
    end else if (sink_wait > 0) begin
      sink_wait--;
    end
    out_stall <= sink_hold || (sink_wait > 0);
  end

  // Long receiver hold-off, requested by the test sequence.
  initial begin : long_hold
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        sink_hold <= 1'b1;
        repeat (hold_request) @(posedge clk);
        sink_hold <= 1'b0;
        hold_request = 0;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = $urandom_range(0, in_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    do @(posedge clk); while (in_stall);
    track_byte(b);
    items_sent++;
  endtask

  task automatic send_line(input string s);
    for (int k = 0; k < s.len(); k++) send_byte(s[k]);
    send_byte(NEWLINE_CODE);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_matches.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr[2] == REG_IDX_LAG) lag_cfg = data[LAG_W-1:0];
  endtask

  task automatic check_lag();
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= LAG_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[LAG_W-1:0] !== lag_cfg) begin
      $display("%0t: lag readback mismatch, expected %0d, actual %0d",
               $time, lag_cfg, prdata[LAG_W-1:0]);
      note_error();
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic test_default_lag();
    in_gap_max = 3;
    out_gap_max = 3;
    check_lag();
    send_line("ab");
    send_line("ab");
    send_line("");
    send_line("");
    send_byte(8'hFF);
    send_byte(8'h01);
    send_byte(NEWLINE_CODE);
    send_byte(8'hFF);
    send_byte(8'h01);
    send_byte(NEWLINE_CODE);
    // Bytes after a zero byte do not take part in the compare.
    send_byte("x");
    send_byte(ZERO_BYTE);
    send_byte("y");
    send_byte(NEWLINE_CODE);
    send_byte("x");
    send_byte(ZERO_BYTE);
    send_byte("q");
    send_byte("q");
    send_byte(NEWLINE_CODE);
    send_line("abc");
  endtask

  task automatic test_lag_zero();
    drain();
    cfg_write(LAG_ADDR, 32'hFFFF_FFF0);
    check_lag();
    send_line("q");
    send_line("");
    send_byte(8'h80);
    send_byte(NEWLINE_CODE);
  endtask

  task automatic test_lag_max();
    drain();
    cfg_write(LAG_ADDR, 32'h0000_000F);
    cfg_write(UNUSED_ADDR, 32'h0000_0003);
    check_lag();
    send_line("first");
    for (int k = 0; k < 14; k++) send_line($sformatf("f%0d", k));
    send_line("first");
  endtask

  task automatic test_midline_lag();
    drain();
    cfg_write(LAG_ADDR, 32'h0000_0001);
    send_line("abc");
    send_line("xyz");
    send_byte("a");
    send_byte("b");
    send_byte("c");
    drain();
    // The lag changes while a line is half received; the newline compares two back.
    cfg_write(LAG_ADDR, 32'h0000_0002);
    send_byte(NEWLINE_CODE);
  endtask

  task automatic test_overlong_lines();
    drain();
    cfg_write(LAG_ADDR, 32'h0000_0000);
    in_gap_max = 1;
    // With lag zero the line reports its own length, which stops one byte short of the slot depth.
    for (int k = 0; k < LINE_BYTES + 2; k++) send_byte(8'(8'h61 + k % 26));
    send_byte(NEWLINE_CODE);
  endtask

  task automatic test_backpressure();
    drain();
    cfg_write(LAG_ADDR, 32'h0000_0000);
    in_gap_max = 0;
    out_gap_max = 0;
    hold_request = 200;
    for (int k = 0; k < 30; k++) send_line($sformatf("p%0d", k));
  endtask

  // Mostly repeats of the line one lag back, some with a hidden tail or a
  // one-byte change, plus fresh lines and raw noise.
  task automatic random_lines(input int n_items);
    logic [7:0] text[$];
    int start_count;
    int unsigned lag;
    int unsigned other;
    int pick;
    int variant;
    int pos;
    logic [7:0] b;
    start_count = items_sent;
    while (items_sent - start_count < n_items) begin
      text.delete();
      lag = (lag_cfg > MAX_SLOTS - 1) ? MAX_SLOTS - 1 : lag_cfg;
      pick = $urandom_range(0, 99);
      if (pick < 60 && lag > 0 && lines_done >= lag) begin
        other = (wr_slot + MAX_SLOTS - lag) % MAX_SLOTS;
        for (int k = 0; k < slot_len[other]; k++) text.push_back(line_mem[other][k]);
        variant = $urandom_range(0, 9);
        if (variant < 3) begin
          text.push_back(ZERO_BYTE);
          repeat ($urandom_range(0, 3)) begin
            do b = 8'($urandom_range(0, 255)); while (b == NEWLINE_CODE);
            text.push_back(b);
          end
        end else if (variant == 3) begin
          text.push_back(8'h7A);
        end else if (variant == 4 && text.size() > 0) begin
          pos = $urandom_range(0, text.size() - 1);
          do text[pos]++; while (text[pos] == NEWLINE_CODE || text[pos] == ZERO_BYTE);
        end
        foreach (text[k]) send_byte(text[k]);
        send_byte(NEWLINE_CODE);
      end else if (pick < 90) begin
        repeat ($urandom_range(0, 12)) begin
          if ($urandom_range(0, 1)) begin
            b = 8'(8'h61 + $urandom_range(0, 1));
          end else begin
            do b = 8'($urandom_range(0, 255)); while (b == NEWLINE_CODE);
          end
          send_byte(b);
        end
        send_byte(NEWLINE_CODE);
      end else begin
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
      end
    end
  endtask

  task automatic test_random();
    logic [LAG_W-1:0] lags [4];
    int in_gaps [4];
    int out_gaps [4];
    lags = '{4'd3, 4'd0, 4'd15, 4'($urandom_range(1, 14))};
    in_gaps = '{10, 0, 10, 0};
    out_gaps = '{10, 0, 0, 10};
    for (int p = 0; p < 4; p++) begin
      drain();
      cfg_write(LAG_ADDR, {28'($urandom), lags[p]});
      check_lag();
      in_gap_max = in_gaps[p];
      out_gap_max = out_gaps[p];
      random_lines(30);
    end
  endtask

  task automatic test_unterminated_line();
    // No newline follows the second copy of the line, so that copy is never compared.
    send_line("tail");
    send_byte("t");
    send_byte("a");
    send_byte("i");
    send_byte("l");
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_default_lag();
    test_lag_zero();
    test_lag_max();
    test_midline_lag();
    test_overlong_lines();
    test_backpressure();
    test_random();
    test_unterminated_line();
    drain();
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
